/* src/pve_pkg.sv */
`timescale 1ns / 1ps
package pve_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);

  localparam logic [3:0] MODE_CGA4   = 4'd0;
  localparam logic [3:0] MODE_CGA2   = 4'd1;
  localparam logic [3:0] MODE_MONO   = 4'd2;
  localparam logic [3:0] MODE_TGA160 = 4'd3;
  localparam logic [3:0] MODE_TGA320 = 4'd4;
  localparam logic [3:0] MODE_TGA640 = 4'd5;
  localparam logic [3:0] MODE_EGA320 = 4'd6;
  localparam logic [3:0] MODE_EGA640 = 4'd7;
  localparam logic [3:0] MODE_VGA8   = 4'd8;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_FG       = 3'd1;
  localparam logic [2:0] REG_ZERO_FG  = 3'd2;
  localparam logic [2:0] REG_FL_LINE  = 3'd3;
  localparam logic [2:0] REG_FL_FRAME = 3'd4;
  localparam logic [2:0] REG_SYNC     = 3'd5;

  localparam logic        OP_EXPAND   = 1'b0;
  localparam logic        OP_PAL_WR   = 1'b1;

  localparam logic [3:0]  MODE_RESET  = MODE_TGA320;
  localparam logic [15:0] SYNC_RESET  = 16'hc0c0;
  localparam logic [7:0]  MONO_FG     = 8'd15;
  localparam logic [7:0]  DIV_STEP    = 8'd42;

  localparam logic [1:0] DITHER_T0 [8] = '{2'd0, 2'd0, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3};
  localparam logic [1:0] DITHER_T1 [8] = '{2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3};

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  fg;
    logic        zero_fg;
    logic        fl_line;
    logic        fl_frame;
    logic [15:0] sync;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] word;
    logic        line_odd;
    logic        frame_odd;
    logic [7:0]  pidx;
    logic [23:0] rgb;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [PAL_AW-1:0] addr;
    logic              bank;
    logic              narrow;
    logic              last;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    logic [PAL_AW-1:0] addr;
    logic [31:0]       data;   // bank b in the upper half
  } wr_req_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic        narrow;
    logic        last;
  } pix_t;

  // Power-up contents of one entry, bank b in the upper half.
  function automatic logic [31:0] pal_default(input logic [PAL_AW-1:0] addr);
    logic [7:0] v;
    logic [7:0] hi;
    logic [7:0] lo;
    v  = 8'(addr);
    hi = {2'b11, DITHER_T0[v[7:5]], DITHER_T0[v[4:2]], v[1:0]};
    lo = {2'b11, DITHER_T1[v[7:5]], DITHER_T1[v[4:2]], v[1:0]};
    return {lo, hi, hi, lo};
  endfunction

  // Channel value divided by 42, result 0..6.
  function automatic logic [2:0] div42(input logic [7:0] c);
    logic [2:0] q;
    q = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if ({1'b0, c} >= 9'(k * 42)) q = 3'(k);
    end
    return q;
  endfunction

endpackage

/* src/pve_ram.sv */
`timescale 1ns / 1ps
module pve_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* src/pve_seq.sv */
`timescale 1ns / 1ps
module pve_seq (
  input  logic             clk,
  input  logic             rst,
  input  pve_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  pve_pkg::item_t   item,
  input  logic             can_issue,
  output pve_pkg::rd_req_t rd,
  output pve_pkg::wr_req_t wr
);

  logic        busy;
  logic        op;
  logic [31:0] word;
  logic        bank;
  logic [2:0]  cnt;
  logic [2:0]  nlast;
  logic [7:0]  widx;
  logic [23:0] wrgb;

  logic [2:0]  nlast_next;
  logic        narrow;
  logic [7:0]  idx;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [7:0]  b3;
  logic [2:0]  rev;
  logic [3:0]  nib;
  logic        fire;
  logic        done;
  logic [5:0]  hi;
  logic [5:0]  lo;
  logic [2:0]  qr;
  logic [2:0]  qg;
  logic [2:0]  qb;

  always_comb begin
    b0  = word[7:0];
    b1  = word[15:8];
    b2  = word[23:16];
    b3  = word[31:24];
    rev = ~cnt;
    nib = 4'd0;
    idx = b0;
    nlast_next = 3'd0;
    narrow = 1'b0;
    case (cfg.mode) inside
      pve_pkg::MODE_CGA4: begin
        nlast_next = 3'd3;
      end
      pve_pkg::MODE_CGA2, pve_pkg::MODE_MONO: begin
        nlast_next = 3'd7;
        narrow = 1'b1;
      end
      pve_pkg::MODE_TGA160: begin
        nlast_next = 3'd3;
      end
      pve_pkg::MODE_TGA320: begin
        nlast_next = 3'd1;
      end
      pve_pkg::MODE_TGA640: begin
        nlast_next = 3'd1;
        narrow = 1'b1;
      end
      pve_pkg::MODE_EGA320: begin
        nlast_next = 3'd7;
      end
      pve_pkg::MODE_EGA640: begin
        nlast_next = 3'd7;
        narrow = 1'b1;
      end
      pve_pkg::MODE_VGA8: begin
        nlast_next = 3'd3;
      end
      default: begin
        nlast_next = 3'd0;
      end
    endcase

    // Pixel index for slot cnt, leftmost pixel first.
    case (cfg.mode) inside
      pve_pkg::MODE_CGA4: idx = {6'd0, b0[{~cnt[1:0], 1'b1} -: 2]};
      pve_pkg::MODE_CGA2: idx = b0[rev] ? cfg.fg : 8'd0;
      pve_pkg::MODE_MONO: idx = b0[rev] ? pve_pkg::MONO_FG : 8'd0;
      pve_pkg::MODE_TGA160: begin
        nib = cnt[1] ? b0[3:0] : b0[7:4];
        idx = (cfg.zero_fg && nib == 4'd0) ? cfg.fg : {4'd0, nib};
      end
      pve_pkg::MODE_TGA320, pve_pkg::MODE_TGA640: begin
        idx = {4'd0, cnt[0] ? b0[3:0] : b0[7:4]};
      end
      pve_pkg::MODE_EGA320, pve_pkg::MODE_EGA640: begin
        idx = {4'd0, b3[rev], b2[rev], b1[rev], b0[rev]};
      end
      pve_pkg::MODE_VGA8: idx = word[{cnt[1:0], 3'b000} +: 8];
      default: idx = b0;
    endcase
  end

  always_comb begin
    qr = pve_pkg::div42(wrgb[23:16]);
    qg = pve_pkg::div42(wrgb[15:8]);
    qb = pve_pkg::div42(wrgb[7:0]);
    hi = {pve_pkg::DITHER_T0[qr], pve_pkg::DITHER_T0[qg], pve_pkg::DITHER_T0[qb]};
    lo = {pve_pkg::DITHER_T1[qr], pve_pkg::DITHER_T1[qg], pve_pkg::DITHER_T1[qb]};
  end

  assign fire     = busy && (op || can_issue);
  assign done     = op || (cnt == nlast);
  assign in_ready = !busy || (fire && done);

  always_comb begin
    rd.valid  = busy && !op && can_issue;
    rd.addr   = idx[pve_pkg::PAL_AW-1:0];
    rd.bank   = bank;
    rd.narrow = narrow;
    rd.last   = (cnt == nlast);
    wr.valid  = busy && op;
    wr.addr   = widx[pve_pkg::PAL_AW-1:0];
    wr.data   = {({2'b00, lo, 2'b00, hi} | cfg.sync), ({2'b00, hi, 2'b00, lo} | cfg.sync)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      if (in_valid && in_ready) begin
        busy  <= 1'b1;
        cnt   <= 3'd0;
        op    <= item.op;
        word  <= item.word;
        bank  <= (item.line_odd & cfg.fl_line) ^ (item.frame_odd & cfg.fl_frame);
        nlast <= nlast_next;
        widx  <= item.pidx;
        wrgb  <= item.rgb;
      end else if (fire && done) begin
        busy <= 1'b0;
      end else if (fire) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

/* src/pve_palette.sv */
`timescale 1ns / 1ps
module pve_palette (
  input  logic             clk,
  input  logic             rst,
  input  pve_pkg::rd_req_t rd,
  input  pve_pkg::wr_req_t wr,
  output pve_pkg::pix_t    pix
);

  logic [pve_pkg::PAL_ENTRIES-1:0] written;
  logic                            s1_valid;
  logic                            s1_written;
  logic [pve_pkg::PAL_AW-1:0]      s1_addr;
  logic                            s1_bank;
  logic                            s1_narrow;
  logic                            s1_last;
  logic [31:0]                     ram_q;
  logic [31:0]                     entry;
  logic [15:0]                     phase;

  pve_ram #(
    .WIDTH(32),
    .DEPTH(pve_pkg::PAL_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr.valid),
    .waddr(wr.addr),
    .wdata(wr.data),
    .raddr(rd.addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (wr.valid) written[wr.addr] <= 1'b1;
      s1_valid <= rd.valid;
    end
    s1_written <= written[rd.addr];
    s1_addr    <= rd.addr;
    s1_bank    <= rd.bank;
    s1_narrow  <= rd.narrow;
    s1_last    <= rd.last;
  end

  // An entry never written reads as its power-up ramp value.
  always_comb begin
    entry      = s1_written ? ram_q : pve_pkg::pal_default(s1_addr);
    phase      = s1_bank ? entry[31:16] : entry[15:0];
    pix.valid  = s1_valid;
    pix.value  = s1_narrow ? {8'd0, phase[7:0]} : phase;
    pix.narrow = s1_narrow;
    pix.last   = s1_last;
  end

endmodule

/* src/pve_oq.sv */
`timescale 1ns / 1ps
module pve_oq (
  input  logic          clk,
  input  logic          rst,
  input  pve_pkg::pix_t pix,
  output logic          can_issue,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tuser,
  output logic          m_tlast
);

  typedef struct packed {
    logic [15:0] value;
    logic        narrow;
    logic        last;
  } beat_t;

  beat_t      ents [2];
  logic       wp;
  logic       rp;
  logic [1:0] occ;
  logic       pop;

  assign m_tvalid = (occ != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = ents[rp].value;
  assign m_tuser  = ents[rp].narrow;
  assign m_tlast  = ents[rp].last;

  // Issue only when the beat in flight and this one both find a slot.
  assign can_issue = ({1'b0, occ} + {2'b00, pix.valid}) < (3'd2 + {2'b00, pop});

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      occ <= 2'd0;
    end else begin
      if (pix.valid) begin
        ents[wp] <= '{value: pix.value, narrow: pix.narrow, last: pix.last};
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      occ <= occ + {1'b0, pix.valid} - {1'b0, pop};
    end
  end

endmodule

/* src/retro_video_pixel_expander_unit.sv */
`timescale 1ns / 1ps
// Unpacks one video memory word into one to eight palette-mapped pixels and
// sends them one beat per clock while the output queue has room. An expand
// word has 1 to 8 pixels (4 in cga4, tga160 and vga packed, 8 in cga2, mono
// and ega, 2 in tga320/640, 1 in vga linear), read one at a time through
// the single read port of the palette RAM; the next word is taken in the
// cycle its last pixel issues. A palette write beat produces no output beat.
// Each pixel passes the palette read register and the output queue before it
// appears. The palette RAM needs no clearing pass after reset: entries that
// were never written read as the default dithered ramp.
module retro_video_pixel_expander_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pixel_word[31:0], line_odd[32], frame_odd[33], palette_index[41:34],
  // color_rgb[65:42], zero pad [71:66]
  input  logic [71:0] s_tdata,
  // operation[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_value[15:0]
  output logic [15:0] m_tdata,
  // narrow_pixel[0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pve_pkg::cfg_t    cfg;
  pve_pkg::item_t   item;
  pve_pkg::rd_req_t rd;
  pve_pkg::wr_req_t wr;
  pve_pkg::pix_t    pix;
  logic             can_issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= pve_pkg::MODE_RESET;
      cfg.fg       <= 8'd0;
      cfg.zero_fg  <= 1'b0;
      cfg.fl_line  <= 1'b0;
      cfg.fl_frame <= 1'b0;
      cfg.sync     <= pve_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pve_pkg::REG_MODE:     cfg.mode     <= cfg_data[3:0];
        pve_pkg::REG_FG:       cfg.fg       <= cfg_data[7:0];
        pve_pkg::REG_ZERO_FG:  cfg.zero_fg  <= cfg_data[0];
        pve_pkg::REG_FL_LINE:  cfg.fl_line  <= cfg_data[0];
        pve_pkg::REG_FL_FRAME: cfg.fl_frame <= cfg_data[0];
        pve_pkg::REG_SYNC:     cfg.sync     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.op        = s_tuser;
    item.word      = s_tdata[31:0];
    item.line_odd  = s_tdata[32];
    item.frame_odd = s_tdata[33];
    item.pidx      = s_tdata[41:34];
    item.rgb       = s_tdata[65:42];
  end

  pve_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .item     (item),
    .can_issue(can_issue),
    .rd       (rd),
    .wr       (wr)
  );

  pve_palette u_palette (
    .clk(clk),
    .rst(rst),
    .rd (rd),
    .wr (wr),
    .pix(pix)
  );

  pve_oq u_oq (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .can_issue(can_issue),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/pve_check.sv */
`timescale 1ns / 1ps
module pve_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Nothing left over from before reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("output valid or input stalled right after reset");

  // Narrow pixels carry only the low byte.
  a_narrow_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[15:8] == 8'd0)
    else $error("narrow pixel with nonzero upper byte");

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // Width class does not change inside one word.
  a_word_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser == $past(m_tuser))
    else $error("narrow flag changed within a word");

endmodule

bind retro_video_pixel_expander_unit pve_check u_check (.*);

/* tb/pixel_expander_checker.sv */
`timescale 1ns / 1ps
module pixel_expander_checker
  import pve_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [15:0] value;
    logic        narrow;
    logic        last;
  } pixel_beat_t;

  logic [15:0] phase_a [PAL_ENTRIES];
  logic [15:0] phase_b [PAL_ENTRIES];

  logic [3:0]  cur_mode;
  logic [7:0]  fg_index;
  logic        zero_fg;
  logic        bank_on_line;
  logic        bank_on_frame;
  logic [15:0] sync_bits;

  pixel_beat_t expected_pixels [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Power-up ramp: 3-3-2 index split, red and green run through the dither tables.
  task automatic load_default_palette();
    logic [7:0] v;
    logic [7:0] hi;
    logic [7:0] lo;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      v  = 8'(i);
      hi = {2'b11, DITHER_T0[v[7:5]], DITHER_T0[v[4:2]], v[1:0]};
      lo = {2'b11, DITHER_T1[v[7:5]], DITHER_T1[v[4:2]], v[1:0]};
      phase_a[i] = {hi, lo};
      phase_b[i] = {lo, hi};
    end
  endtask

  task automatic store_color(input logic [7:0] entry, input logic [23:0] rgb);
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    logic [5:0] hi;
    logic [5:0] lo;
    r  = 3'(rgb[23:16] / DIV_STEP);
    g  = 3'(rgb[15:8] / DIV_STEP);
    b  = 3'(rgb[7:0] / DIV_STEP);
    hi = {DITHER_T0[r], DITHER_T0[g], DITHER_T0[b]};
    lo = {DITHER_T1[r], DITHER_T1[g], DITHER_T1[b]};
    phase_a[entry] = {2'b00, hi, 2'b00, lo} | sync_bits;
    phase_b[entry] = {2'b00, lo, 2'b00, hi} | sync_bits;
  endtask

  task automatic expand_word(input logic [31:0] word, input logic line_odd,
                             input logic frame_odd);
    logic        bank;
    logic [7:0]  idx [8];
    logic [7:0]  lo_byte;
    logic [3:0]  p1;
    logic [3:0]  p2;
    logic        narrow;
    logic [15:0] value;
    int          count;
    bank    = (line_odd & bank_on_line) ^ (frame_odd & bank_on_frame);
    lo_byte = word[7:0];
    narrow  = 1'b0;
    count   = 0;
    case (cur_mode)
      MODE_CGA4: begin
        for (int k = 0; k < 4; k++) idx[k] = 8'(lo_byte[7 - 2 * k -: 2]);
        count = 4;
      end
      MODE_CGA2, MODE_MONO: begin
        for (int k = 0; k < 8; k++) begin
          if (!lo_byte[7 - k]) idx[k] = 8'd0;
          else idx[k] = (cur_mode == MODE_CGA2) ? fg_index : MONO_FG;
        end
        narrow = 1'b1;
        count  = 8;
      end
      MODE_TGA160: begin
        p1 = lo_byte[7:4];
        p2 = lo_byte[3:0];
        idx[0] = (zero_fg && p1 == 4'd0) ? fg_index : 8'(p1);
        idx[2] = (zero_fg && p2 == 4'd0) ? fg_index : 8'(p2);
        idx[1] = idx[0];
        idx[3] = idx[2];
        count  = 4;
      end
      MODE_TGA320, MODE_TGA640: begin
        idx[0] = 8'(lo_byte[7:4]);
        idx[1] = 8'(lo_byte[3:0]);
        narrow = (cur_mode == MODE_TGA640);
        count  = 2;
      end
      MODE_EGA320, MODE_EGA640: begin
        // plane 3 is the top byte and gives the top index bit
        for (int k = 0; k < 8; k++)
          idx[k] = {4'b0000, word[31 - k], word[23 - k], word[15 - k], word[7 - k]};
        narrow = (cur_mode == MODE_EGA640);
        count  = 8;
      end
      MODE_VGA8: begin
        for (int k = 0; k < 4; k++) idx[k] = word[8 * k +: 8];
        count = 4;
      end
      default: begin
        // vga linear and every spare mode code
        idx[0] = lo_byte;
        count  = 1;
      end
    endcase
    for (int k = 0; k < count; k++) begin
      value = bank ? phase_b[idx[k]] : phase_a[idx[k]];
      if (narrow) value = {8'h00, value[7:0]};
      expected_pixels.push_back('{value: value, narrow: narrow, last: (k == count - 1)});
    end
  endtask

  task automatic check_beat();
    pixel_beat_t want;
    if (expected_pixels.size() == 0) begin
      report("pixel with nothing expected", m_tdata, 16'h0000);
    end else begin
      want = expected_pixels.pop_front();
      if (m_tdata !== want.value) report("pixel_value", m_tdata, want.value);
      if (m_tuser !== want.narrow) report("narrow_pixel", 16'(m_tuser), 16'(want.narrow));
      if (m_tlast !== want.last) report("last_pixel", 16'(m_tlast), 16'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      load_default_palette();
      cur_mode      = MODE_RESET;
      fg_index      = 8'd0;
      zero_fg       = 1'b0;
      bank_on_line  = 1'b0;
      bank_on_frame = 1'b0;
      sync_bits     = SYNC_RESET;
      expected_pixels.delete();
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     cur_mode      = cfg_data[3:0];
          REG_FG:       fg_index      = cfg_data[7:0];
          REG_ZERO_FG:  zero_fg       = cfg_data[0];
          REG_FL_LINE:  bank_on_line  = cfg_data[0];
          REG_FL_FRAME: bank_on_frame = cfg_data[0];
          REG_SYNC:     sync_bits     = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_PAL_WR) store_color(s_tdata[41:34], s_tdata[65:42]);
        else expand_word(s_tdata[31:0], s_tdata[32], s_tdata[33]);
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* tb/tb_retro_video_pixel_expander_unit.sv */
`timescale 1ns / 1ps
module tb_retro_video_pixel_expander_unit;
  import pve_pkg::*;

  localparam logic [3:0] MODE_VGA_LIN   = 4'd9;
  localparam logic [3:0] MODE_LAST_CODE = 4'd15;
  localparam int RESULT_LATENCY  = 4;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 12;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int pending;
  int fail_count;
  int idle_cycles;
  int stall_left;
  bit calm;

  retro_video_pixel_expander_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_expander_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias channels toward the divide-by-42 step edges.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd41;
      3: return 8'd42;
      4: return 8'd251;
      5: return 8'd252;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic op, input logic [31:0] word, input logic line_odd,
                           input logic frame_odd, input logic [7:0] pidx,
                           input logic [23:0] rgb);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {6'b000000, rgb, pidx, frame_odd, line_odd, word};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_item();
    logic op;
    op = ($urandom_range(0, 4) == 0) ? OP_PAL_WR : OP_EXPAND;
    send_beat(op, pick_word(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)), {pick_channel(), pick_channel(), pick_channel()});
  endtask

  // Drop valid and hold until every pixel is out and a palette write has landed.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic pick_config();
    logic [15:0] sync;
    logic [3:0]  mode;
    case ($urandom_range(0, 3))
      0: sync = 16'h0000;
      1: sync = 16'hffff;
      2: sync = SYNC_RESET;
      default: sync = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 7) == 0) mode = 4'($urandom_range(MODE_VGA_LIN + 1, MODE_LAST_CODE));
    else mode = 4'($urandom_range(MODE_CGA4, MODE_VGA_LIN));
    write_reg(REG_MODE, 16'(mode));
    write_reg(REG_FG, 16'(pick_channel()));
    write_reg(REG_ZERO_FG, 16'($urandom_range(0, 1)));
    write_reg(REG_FL_LINE, 16'($urandom_range(0, 1)));
    write_reg(REG_FL_FRAME, 16'($urandom_range(0, 1)));
    write_reg(REG_SYNC, sync);
  endtask

  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: any accepted beat on either side restarts the count.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    calm      = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_EXPAND;
    cfg_we    = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Palette writes at the index and colour extremes, one just under a step edge.
    send_beat(OP_PAL_WR, 32'hffff_ffff, 1'b1, 1'b1, 8'd0, 24'h000000);
    send_beat(OP_PAL_WR, 32'h0000_0000, 1'b0, 1'b0, 8'd255, 24'hffffff);
    send_beat(OP_PAL_WR, $urandom, 1'b0, 1'b1, 8'd15, 24'h2a2a29);

    // Reset mode, word extremes.
    send_beat(OP_EXPAND, 32'h0000_0000, 1'b0, 1'b0, 8'd0, 24'h000000);
    send_beat(OP_EXPAND, 32'hffff_ffff, 1'b1, 1'b1, 8'd255, 24'hffffff);

    // Every mode once, plus one spare code.
    settle();
    write_reg(REG_FG, 16'd255);
    for (int m = MODE_CGA4; m <= MODE_VGA_LIN + 1; m++) begin
      settle();
      write_reg(REG_MODE, 16'(m));
      send_beat(OP_EXPAND, 32'h5ac3_0f96, 1'b0, 1'b0, 8'($urandom), 24'($urandom));
    end

    // tga160 with zero substitution: the high nibble is zero, the low one is not.
    settle();
    write_reg(REG_MODE, 16'(MODE_TGA160));
    write_reg(REG_ZERO_FG, 16'd1);
    send_beat(OP_EXPAND, 32'h0000_000f, 1'b0, 1'b0, 8'd0, 24'h000000);

    // Bank flashing by line and by frame, both cancel at odd line and odd frame.
    settle();
    write_reg(REG_MODE, 16'(MODE_VGA8));
    write_reg(REG_FL_LINE, 16'd1);
    write_reg(REG_FL_FRAME, 16'd1);
    write_reg(REG_SYNC, 16'h0000);
    send_beat(OP_EXPAND, 32'h0fff_0100, 1'b1, 1'b0, 8'd0, 24'h000000);
    send_beat(OP_EXPAND, 32'h0fff_0100, 1'b1, 1'b1, 8'd0, 24'h000000);
    send_beat(OP_EXPAND, 32'h0fff_0100, 1'b0, 1'b1, 8'd0, 24'h000000);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      pick_config();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_item();
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pve_pkg.sv
src/pve_ram.sv
src/pve_seq.sv
src/pve_palette.sv
src/pve_oq.sv
src/retro_video_pixel_expander_unit.sv
src/pve_check.sv
tb/pixel_expander_checker.sv
tb/tb_retro_video_pixel_expander_unit.sv
